FILE: sv/ura_pkg.sv
package ura_pkg;

   // Datapath sizing
   localparam int VALUE_BITS  = 64;
   localparam int MAX_DIGITS  = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int STEP_BITS   = $clog2(VALUE_BITS);
   localparam int COUNT_BITS  = $clog2(MAX_DIGITS + 1);

   localparam int RADIX_BITS  = 6;
   localparam int DIGIT_BITS  = 6;
   localparam int CASE_BITS   = 2;
   localparam int CHAR_BITS   = 8;
   localparam int TOTAL_BITS  = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);

   // Letter case modes
   localparam logic [CASE_BITS-1:0] CASE_RAW   = 2'd0;
   localparam logic [CASE_BITS-1:0] CASE_LOWER = 2'd1;
   localparam logic [CASE_BITS-1:0] CASE_UPPER = 2'd2;

   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = 8'd48;
   localparam logic [CHAR_BITS-1:0]  CHAR_UPPER_A  = 8'd65;
   localparam logic [CHAR_BITS-1:0]  CHAR_LOWER_A  = 8'd97;
   localparam logic [DIGIT_BITS-1:0] DECIMAL_LIMIT = 6'd10;

   typedef logic [CHAR_BITS-1:0] char_type;

   function automatic char_type ascii_of_digit(input logic [DIGIT_BITS-1:0] digit,
                                               input logic [CASE_BITS-1:0]  mode);
      char_type wide_digit;
      char_type result;
      wide_digit = {{(CHAR_BITS - DIGIT_BITS){1'b0}}, digit};
      if (digit >= DECIMAL_LIMIT && mode == CASE_UPPER) begin
         result = wide_digit - {2'b00, DECIMAL_LIMIT} + CHAR_UPPER_A;
      end else if (digit >= DECIMAL_LIMIT && mode == CASE_LOWER) begin
         result = wide_digit - {2'b00, DECIMAL_LIMIT} + CHAR_LOWER_A;
      end else begin
         result = wide_digit + CHAR_ZERO;
      end
      return result;
   endfunction

endpackage

FILE: sv/ura_ram.sv
module ura_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/unsigned_to_radix_ascii.sv
// Converts an unsigned value to ASCII digits in radix 2..36 (out-of-range radix saturates),
// emitting one character word per rsp_ handshake, most significant digit first, with
// rsp_last on the final one and the character count on every word. A zero value gives "0".
// Digits come from one restoring divider that retires one quotient bit per cycle; they go
// into a 64-entry digit RAM and are read back in reverse, each character passing through
// the READ, LOAD and SEND states and waiting in SEND for rsp_ready; req_ready is high only
// between items.
module unsigned_to_radix_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value,
   input  logic [5:0]  req_radix,
   input  logic [1:0]  req_letter_case,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_character,
   output logic [6:0]  rsp_digit_total,
   output logic        rsp_last
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_SEND = 3'd4;

   logic [2:0]                         state_ff, state_in;
   logic [ura_pkg::VALUE_BITS-1:0]     quot_ff, quot_in;
   logic [ura_pkg::DIGIT_BITS-1:0]     rem_ff, rem_in;
   logic [ura_pkg::RADIX_BITS-1:0]     radix_ff, radix_in;
   logic [ura_pkg::CASE_BITS-1:0]      mode_ff, mode_in;
   logic [ura_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic [ura_pkg::COUNT_BITS-1:0]     count_ff, count_in;
   logic [ura_pkg::ADDR_BITS-1:0]      ptr_ff, ptr_in;
   ura_pkg::char_type                  char_ff, char_in;

   logic [ura_pkg::DIGIT_BITS:0]       trial;
   logic                               quot_bit;
   logic [ura_pkg::DIGIT_BITS-1:0]     rem_step;
   logic [ura_pkg::VALUE_BITS-1:0]     quot_step;
   logic [ura_pkg::COUNT_BITS-1:0]     count_next;
   logic [ura_pkg::RADIX_BITS-1:0]     radix_sat;

   logic                               ram_wr_en;
   logic                               ram_rd_en;
   logic [ura_pkg::DIGIT_BITS-1:0]     ram_rd_data;

   // One restoring divide step: shift in the next dividend bit, subtract if it fits
   assign trial    = {rem_ff, quot_ff[ura_pkg::VALUE_BITS-1]};
   assign quot_bit = (trial >= {1'b0, radix_ff});
   assign rem_step = quot_bit ? ura_pkg::DIGIT_BITS'(trial - {1'b0, radix_ff})
                              : trial[ura_pkg::DIGIT_BITS-1:0];
   assign quot_step  = {quot_ff[ura_pkg::VALUE_BITS-2:0], quot_bit};
   assign count_next = count_ff + ura_pkg::COUNT_BITS'(1);

   always_comb begin
      if (req_radix < ura_pkg::RADIX_MIN) begin
         radix_sat = ura_pkg::RADIX_MIN;
      end else if (req_radix > ura_pkg::RADIX_MAX) begin
         radix_sat = ura_pkg::RADIX_MAX;
      end else begin
         radix_sat = req_radix;
      end
   end

   assign ram_wr_en = (state_ff == ST_DIV) && (step_ff == '0);
   assign ram_rd_en = (state_ff == ST_READ);

   always_comb begin
      state_in = state_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      mode_in  = mode_ff;
      step_in  = step_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      char_in  = char_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               quot_in  = req_value[ura_pkg::VALUE_BITS-1:0];
               rem_in   = '0;
               radix_in = radix_sat;
               mode_in  = req_letter_case;
               step_in  = ura_pkg::STEP_BITS'(ura_pkg::VALUE_BITS - 1);
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = quot_step;
            rem_in  = rem_step;
            step_in = step_ff - ura_pkg::STEP_BITS'(1);
            if (step_ff == '0) begin
               // Digit done: store it, then divide again or start reading back
               count_in = count_next;
               rem_in   = '0;
               step_in  = ura_pkg::STEP_BITS'(ura_pkg::VALUE_BITS - 1);
               if (quot_step == '0 ||
                   count_next >= ura_pkg::COUNT_BITS'(ura_pkg::MAX_DIGITS)) begin
                  ptr_in   = count_ff[ura_pkg::ADDR_BITS-1:0];
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            char_in  = ura_pkg::ascii_of_digit(ram_rd_data, mode_ff);
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff - ura_pkg::ADDR_BITS'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         quot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         quot_ff  <= quot_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      mode_ff  <= mode_in;
      step_ff  <= step_in;
      ptr_ff   <= ptr_in;
      char_ff  <= char_in;
   end

   ura_ram #(
      .WIDTH (ura_pkg::DIGIT_BITS),
      .DEPTH (ura_pkg::STORE_DEPTH)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ura_pkg::ADDR_BITS-1:0]),
      .wr_data (rem_step),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_SEND);
   assign rsp_character   = char_ff;
   assign rsp_digit_total = ura_pkg::TOTAL_BITS'(count_ff);
   assign rsp_last        = (ptr_ff == '0);

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a character word is pending");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < radix_ff))
      else $error("divider remainder not below radix");

   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (radix_ff >= ura_pkg::RADIX_MIN &&
                                 radix_ff <= ura_pkg::RADIX_MAX))
      else $error("latched radix out of range");

   a_ptr_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, ptr_ff} < count_ff))
      else $error("read pointer beyond digit count");

   a_gap_after_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (!rsp_valid && !req_ready))
      else $error("next word shown before digit readback");
`endif

endmodule

FILE: sim/tb_unsigned_to_radix_ascii.sv
module tb_unsigned_to_radix_ascii;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 210;
   localparam int QUIET_ITEMS   = 40;
   localparam int LONG_HOLD     = 3000;
   localparam int DRAIN_CYCLES  = 300;
   localparam logic [ura_pkg::CASE_BITS-1:0]  CASE_SPARE = 2'd3;
   localparam logic [ura_pkg::VALUE_BITS-1:0] MAX_VALUE  = {ura_pkg::VALUE_BITS{1'b1}};

   typedef struct packed {
      logic [ura_pkg::CHAR_BITS-1:0]  code;
      logic [ura_pkg::TOTAL_BITS-1:0] total;
      logic                           last;
   } char_word_type;

   // an empty text means the row is checked against the digit predictor
   typedef struct {
      logic [ura_pkg::VALUE_BITS-1:0] value;
      logic [ura_pkg::RADIX_BITS-1:0] radix;
      logic [ura_pkg::CASE_BITS-1:0]  mode;
      string                          text;
   } conv_row_type;

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [63:0]           req_value       = '0;
   logic [5:0]            req_radix       = 6'd10;
   logic [1:0]            req_letter_case = ura_pkg::CASE_RAW;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [7:0]            rsp_character;
   logic [6:0]            rsp_digit_total;
   logic                  rsp_last;

   char_word_type owed_chars[$];
   char_word_type want_word;
   bit         idle_on       = 1'b1;
   bit         hold_request  = 1'b0;
   int         mismatches    = 0;
   int         chars_checked = 0;
   int         items_sent    = 0;
   int         long_holds    = 0;

   conv_row_type directed_rows [DIRECTED_ROWS] = '{
      '{64'd0,                 6'd10, ura_pkg::CASE_RAW,   "0"},
      '{64'd0,                 6'd2,  ura_pkg::CASE_UPPER, "0"},
      '{64'd1,                 6'd2,  ura_pkg::CASE_LOWER, "1"},
      '{MAX_VALUE,             6'd16, ura_pkg::CASE_UPPER, "FFFFFFFFFFFFFFFF"},
      '{MAX_VALUE,             6'd16, ura_pkg::CASE_LOWER, "ffffffffffffffff"},
      '{MAX_VALUE,             6'd16, ura_pkg::CASE_RAW,   "????????????????"},
      '{MAX_VALUE,             6'd10, ura_pkg::CASE_UPPER, "18446744073709551615"},
      '{MAX_VALUE,             6'd8,  ura_pkg::CASE_RAW,   "1777777777777777777777"},
      '{MAX_VALUE,             6'd2,  ura_pkg::CASE_RAW,   ""},
      '{MAX_VALUE,             6'd36, ura_pkg::CASE_UPPER, ""},
      '{MAX_VALUE,             6'd36, ura_pkg::CASE_LOWER, ""},
      '{MAX_VALUE,             6'd3,  ura_pkg::CASE_RAW,   ""},
      '{64'h8000_0000_0000_0000, 6'd2, ura_pkg::CASE_RAW,  ""},
      '{64'd5,                 6'd0,  ura_pkg::CASE_RAW,   "101"},
      '{64'd6,                 6'd1,  ura_pkg::CASE_RAW,   "110"},
      '{64'd35,                6'd37, ura_pkg::CASE_UPPER, "Z"},
      '{64'd1261,              6'd63, ura_pkg::CASE_LOWER, "z1"},
      '{64'd35,                6'd36, CASE_SPARE,          "S"},
      '{64'd10,                6'd36, ura_pkg::CASE_RAW,   ":"},
      '{64'd1295,              6'd36, ura_pkg::CASE_UPPER, "ZZ"},
      '{64'd10,                6'd11, ura_pkg::CASE_LOWER, "a"},
      '{64'd34,                6'd35, ura_pkg::CASE_UPPER, "Y"},
      '{64'hDEAD_BEEF_0123_4567, 6'd16, ura_pkg::CASE_UPPER, "DEADBEEF01234567"},
      '{64'h5555_5555_5555_5555, 6'd4,  ura_pkg::CASE_LOWER, ""},
      '{64'hAAAA_AAAA_AAAA_AAAA, 6'd35, CASE_SPARE,          ""}
   };

   unsigned_to_radix_ascii dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_radix       (req_radix),
      .req_letter_case (req_letter_case),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_character   (rsp_character),
      .rsp_digit_total (rsp_digit_total),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(60_000_000);
      $display("Timeout with %0d characters still owed", owed_chars.size());
      $display("Regression FAIL");
      $finish;
   end

   task automatic flag_char_error(input string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatches++;
   endtask

   // Repeated division, least significant digit first, then emit in reverse.
   function automatic void predict_radix_chars(
         input logic [ura_pkg::VALUE_BITS-1:0] value,
         input logic [ura_pkg::RADIX_BITS-1:0] radix_in,
         input logic [ura_pkg::CASE_BITS-1:0]  mode);
      logic [ura_pkg::VALUE_BITS-1:0] rest;
      logic [ura_pkg::VALUE_BITS-1:0] base;
      logic [ura_pkg::DIGIT_BITS-1:0] digits [ura_pkg::MAX_DIGITS];
      logic [ura_pkg::CHAR_BITS-1:0]  code;
      char_word_type                  word;
      int                             count;
      if (radix_in < ura_pkg::RADIX_MIN) begin
         base = ura_pkg::VALUE_BITS'(ura_pkg::RADIX_MIN);
      end else if (radix_in > ura_pkg::RADIX_MAX) begin
         base = ura_pkg::VALUE_BITS'(ura_pkg::RADIX_MAX);
      end else begin
         base = ura_pkg::VALUE_BITS'(radix_in);
      end
      rest  = value;
      count = 0;
      do begin
         digits[count] = ura_pkg::DIGIT_BITS'(rest % base);
         count++;
         rest = rest / base;
      end while (rest != 0 && count < ura_pkg::MAX_DIGITS);
      for (int k = count - 1; k >= 0; k--) begin
         if (digits[k] >= ura_pkg::DECIMAL_LIMIT && mode == ura_pkg::CASE_UPPER) begin
            code = ura_pkg::CHAR_UPPER_A +
                   ura_pkg::CHAR_BITS'(digits[k] - ura_pkg::DECIMAL_LIMIT);
         end else if (digits[k] >= ura_pkg::DECIMAL_LIMIT &&
                      mode == ura_pkg::CASE_LOWER) begin
            code = ura_pkg::CHAR_LOWER_A +
                   ura_pkg::CHAR_BITS'(digits[k] - ura_pkg::DECIMAL_LIMIT);
         end else begin
            code = ura_pkg::CHAR_ZERO + ura_pkg::CHAR_BITS'(digits[k]);
         end
         word.code  = code;
         word.total = ura_pkg::TOTAL_BITS'(count);
         word.last  = (k == 0);
         owed_chars.push_back(word);
      end
   endfunction

   function automatic void owe_text(input string text);
      char_word_type word;
      for (int i = 0; i < text.len(); i++) begin
         word.code  = text[i];
         word.total = ura_pkg::TOTAL_BITS'(text.len());
         word.last  = (i == text.len() - 1);
         owed_chars.push_back(word);
      end
   endfunction

   // Offer one word and hold it until the block takes it.
   task automatic send_value(input logic [ura_pkg::VALUE_BITS-1:0] value,
                             input logic [ura_pkg::RADIX_BITS-1:0] radix,
                             input logic [ura_pkg::CASE_BITS-1:0]  mode,
                             input string                          text);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_value       <= value;
      req_radix       <= radix;
      req_letter_case <= mode;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (text.len() != 0) begin
         owe_text(text);
      end else begin
         predict_radix_chars(value, radix, mode);
      end
      items_sent++;
   endtask

   initial begin
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            long_holds++;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_chars.size() == 0) begin
            flag_char_error($sformatf("unexpected word char=%02h total=%0d last=%b",
                                      rsp_character, rsp_digit_total, rsp_last));
         end else begin
            want_word = owed_chars.pop_front();
            chars_checked++;
            if (rsp_character !== want_word.code)
               flag_char_error($sformatf("character %02h, want %02h",
                                         rsp_character, want_word.code));
            if (rsp_digit_total !== want_word.total)
               flag_char_error($sformatf("digit_total %0d, want %0d",
                                         rsp_digit_total, want_word.total));
            if (rsp_last !== want_word.last)
               flag_char_error($sformatf("last %b, want %b", rsp_last, want_word.last));
         end
      end
   end

   initial begin
      logic [ura_pkg::VALUE_BITS-1:0] value;
      logic [ura_pkg::RADIX_BITS-1:0] radix;
      logic [ura_pkg::CASE_BITS-1:0]  mode;
      while (reset) @(posedge clock);

      foreach (directed_rows[i]) begin
         send_value(directed_rows[i].value, directed_rows[i].radix,
                    directed_rows[i].mode, directed_rows[i].text);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 30 == 0) idle_on = ($urandom_range(0, 2) != 0);
         if (i >= RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
         // starve the output so the block backs up onto the input side
         if (i == 60) hold_request = 1'b1;

         value = {$urandom, $urandom};
         case ($urandom_range(0, 15)) inside
            0:       value = '0;
            [1:2]:   ;
            default: value = value >> $urandom_range(1, 63);
         endcase
         if ($urandom_range(0, 9) == 0) begin
            radix = ura_pkg::RADIX_BITS'($urandom_range(0, 63));
         end else begin
            radix = ura_pkg::RADIX_BITS'($urandom_range(2, 36));
         end
         mode = ura_pkg::CASE_BITS'($urandom_range(0, 3));
         send_value(value, radix, mode, "");
      end
      req_valid <= 1'b0;

      while (owed_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d values (%0d directed), %0d characters checked, %0d mismatches",
               items_sent, DIRECTED_ROWS, chars_checked, mismatches);
      $display("Radix 0..63 with saturation, all case modes, %0d long output stall(s)",
               long_holds);
      if (mismatches == 0 && owed_chars.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/ura_pkg.sv
sv/ura_ram.sv
sv/unsigned_to_radix_ascii.sv
sim/tb_unsigned_to_radix_ascii.sv
